// File: rtl/cav_pkg.sv
package cav_pkg;

  // counter width of the length trackers
  localparam int LENGTH_BITS = 13;
  // width of the limit registers
  localparam int LIMIT_BITS  = 13;
  // width used for the length compares
  localparam int CMP_BITS    = (LENGTH_BITS + 1 > LIMIT_BITS) ? LENGTH_BITS + 1 : LIMIT_BITS;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam int SEC_PFX_LEN  = 9;
  localparam int HOST_PFX_LEN = 7;

  localparam logic [LIMIT_BITS-1:0] MAX_COOKIE_RESET = LIMIT_BITS'(4096);
  localparam logic [LIMIT_BITS-1:0] MAX_PATH_RESET   = LIMIT_BITS'(1024);
  localparam logic [LIMIT_BITS-1:0] MAX_DOMAIN_RESET = LIMIT_BITS'(1024);

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [2:0] {
    TAG_NAME  = 3'd0,
    TAG_VALUE = 3'd1,
    TAG_PATH  = 3'd2,
    TAG_HOST  = 3'd3,
    TAG_END   = 3'd4
  } tag_t;

  typedef enum logic [3:0] {
    V_OK           = 4'd0,
    V_EMPTY        = 4'd1,
    V_OVERSIZE     = 4'd2,
    V_BAD_NAME     = 4'd3,
    V_BAD_VALUE    = 4'd4,
    V_PATH_LONG    = 4'd5,
    V_PATH_TAB     = 4'd6,
    V_HOST_LONG    = 4'd7,
    V_PREFIX       = 4'd8,
    V_NONE_SECURE  = 4'd9,
    V_PART_SECURE  = 4'd10
  } verdict_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BLOCK_UNICODE   = 3'd0,
    CFG_NONE_REQ_SECURE = 3'd1,
    CFG_PART_REQ_SECURE = 3'd2,
    CFG_MAX_COOKIE      = 3'd3,
    CFG_MAX_PATH        = 3'd4,
    CFG_MAX_DOMAIN      = 3'd5
  } cfg_index_t;

  localparam logic [1:0] SAME_SITE_NONE = 2'd1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // control characters, semicolon and delete; tab is allowed
  function automatic logic ctrl_illegal(input logic [7:0] c);
    return ((c <= 8'h1F) && (c != CH_TAB)) || (c == CH_SEMI) || (c == CH_DEL);
  endfunction

  // ascii upper to lower folding
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
  endfunction

  // "__secure-" in lower case
  function automatic logic [7:0] sec_pfx_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "_";
      4'd1:    ch = "_";
      4'd2:    ch = "s";
      4'd3:    ch = "e";
      4'd4:    ch = "c";
      4'd5:    ch = "u";
      4'd6:    ch = "r";
      4'd7:    ch = "e";
      4'd8:    ch = "-";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "__host-" in lower case
  function automatic logic [7:0] host_pfx_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "_";
      3'd1:    ch = "_";
      3'd2:    ch = "h";
      3'd3:    ch = "o";
      3'd4:    ch = "s";
      3'd5:    ch = "t";
      3'd6:    ch = "-";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/cav_if.sv
interface cav_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] field_tag;
  logic [7:0] data_byte;
  logic       secure_attr;
  logic [1:0] same_site;
  logic       partitioned_attr;

  modport source (
    output valid, field_tag, data_byte, secure_attr, same_site, partitioned_attr,
    input  ready
  );
  modport sink (
    input  valid, field_tag, data_byte, secure_attr, same_site, partitioned_attr,
    output ready
  );
endinterface

interface cav_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] verdict;
  logic       none_secure_warning;

  modport source (output valid, verdict, none_secure_warning, input ready);
  modport sink (input valid, verdict, none_secure_warning, output ready);
endinterface

interface cav_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/cookie_attribute_validator.sv
// channel   | role   | payload
// cookie    | sink   | field_tag, data_byte, secure_attr, same_site, partitioned_attr
// result    | source | verdict, none_secure_warning
// cfg       | sink   | index, data (register write)
//
// One item per cycle unless stalled: an accepted item is held in the input register, then
// updates the length counters and flags; an end item loads the result register.
// The result register drives the result channel directly.
// Reset (rst, synchronous) restores the registers' reset values and clears the valid flags and cookie state.
// A result waiting at the output holds back only the next end item and the items behind it.
// cfg writes are taken in every cycle.
module cookie_attribute_validator (
  input  logic         clk,
  input  logic         rst,
  cav_item_if.sink     cookie,
  cav_result_if.source result,
  cav_cfg_if.sink      cfg
);
  import cav_pkg::*;

  // configuration registers
  logic                  block_unicode;
  logic                  none_requires_secure;
  logic                  partition_needs_secure;
  logic [LIMIT_BITS-1:0] max_cookie_bytes;
  logic [LIMIT_BITS-1:0] max_path_bytes;
  logic [LIMIT_BITS-1:0] max_domain_bytes;

  // input register
  logic       s1_valid;
  logic [2:0] s1_tag;
  logic [7:0] s1_byte;
  logic       s1_secure;
  logic [1:0] s1_same_site;
  logic       s1_partitioned;

  // cookie state
  logic [LENGTH_BITS-1:0] name_length;
  logic [LENGTH_BITS-1:0] value_length;
  logic [LENGTH_BITS-1:0] path_length;
  logic [LENGTH_BITS-1:0] host_length;
  logic                   name_has_illegal;
  logic                   value_has_illegal;
  logic                   path_has_tab;
  logic                   secure_prefix_alive;
  logic                   host_prefix_alive;

  // result register
  logic       out_valid;
  verdict_t   out_verdict;
  logic       out_warning;

  logic       s1_is_end;
  logic       advance;
  logic       uni_bad;
  logic [7:0] folded;
  verdict_t   verdict_next;
  logic       warning_next;

  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_unicode          <= 1'b0;
      none_requires_secure   <= 1'b1;
      partition_needs_secure <= 1'b1;
      max_cookie_bytes       <= MAX_COOKIE_RESET;
      max_path_bytes         <= MAX_PATH_RESET;
      max_domain_bytes       <= MAX_DOMAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_BLOCK_UNICODE:   block_unicode          <= cfg.data[0];
        CFG_NONE_REQ_SECURE: none_requires_secure   <= cfg.data[0];
        CFG_PART_REQ_SECURE: partition_needs_secure <= cfg.data[0];
        CFG_MAX_COOKIE:      max_cookie_bytes       <= cfg.data;
        CFG_MAX_PATH:        max_path_bytes         <= cfg.data;
        CFG_MAX_DOMAIN:      max_domain_bytes       <= cfg.data;
        default: ;
      endcase
    end
  end

  // an end item moves on only when the result register is free or being read
  assign s1_is_end    = (s1_tag == TAG_END);
  assign advance      = s1_valid && (!s1_is_end || !out_valid || result.ready);
  assign cookie.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cookie.ready) begin
      s1_valid <= cookie.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cookie.ready && cookie.valid) begin
      s1_tag         <= cookie.field_tag;
      s1_byte        <= cookie.data_byte;
      s1_secure      <= cookie.secure_attr;
      s1_same_site   <= cookie.same_site;
      s1_partitioned <= cookie.partitioned_attr;
    end
  end

  assign uni_bad = block_unicode && s1_byte[7];
  assign folded  = fold_lower(s1_byte);

  // per-byte counters and flags, cleared after each end item
  always_ff @(posedge clk) begin
    if (rst) begin
      name_length         <= '0;
      value_length        <= '0;
      path_length         <= '0;
      host_length         <= '0;
      name_has_illegal    <= 1'b0;
      value_has_illegal   <= 1'b0;
      path_has_tab        <= 1'b0;
      secure_prefix_alive <= 1'b1;
      host_prefix_alive   <= 1'b1;
    end else if (advance) begin
      case (tag_t'(s1_tag))
        TAG_NAME: begin
          if (uni_bad || ctrl_illegal(s1_byte) || s1_byte == CH_EQUAL)
            name_has_illegal <= 1'b1;
          if (name_length != LEN_MAX) name_length <= name_length + 1'b1;
        end
        TAG_VALUE: begin
          if (uni_bad || ctrl_illegal(s1_byte)) value_has_illegal <= 1'b1;
          if (value_length < LENGTH_BITS'(SEC_PFX_LEN)
              && folded != sec_pfx_char(value_length[3:0]))
            secure_prefix_alive <= 1'b0;
          if (value_length < LENGTH_BITS'(HOST_PFX_LEN)
              && folded != host_pfx_char(value_length[2:0]))
            host_prefix_alive <= 1'b0;
          if (value_length != LEN_MAX) value_length <= value_length + 1'b1;
        end
        TAG_PATH: begin
          if (s1_byte == CH_TAB) path_has_tab <= 1'b1;
          if (path_length != LEN_MAX) path_length <= path_length + 1'b1;
        end
        TAG_HOST: begin
          if (host_length != LEN_MAX) host_length <= host_length + 1'b1;
        end
        TAG_END: begin
          name_length         <= '0;
          value_length        <= '0;
          path_length         <= '0;
          host_length         <= '0;
          name_has_illegal    <= 1'b0;
          value_has_illegal   <= 1'b0;
          path_has_tab        <= 1'b0;
          secure_prefix_alive <= 1'b1;
          host_prefix_alive   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // verdict in check order
  always_comb begin
    logic [CMP_BITS-1:0] total;
    logic                has_sec;
    logic                has_host;
    logic                none_insecure;
    total         = CMP_BITS'(name_length) + CMP_BITS'(value_length);
    has_sec       = secure_prefix_alive && value_length >= LENGTH_BITS'(SEC_PFX_LEN);
    has_host      = host_prefix_alive && value_length >= LENGTH_BITS'(HOST_PFX_LEN);
    none_insecure = !s1_secure && s1_same_site == SAME_SITE_NONE;
    verdict_next  = V_OK;
    warning_next  = 1'b0;
    if (name_length == '0 && value_length == '0)
      verdict_next = V_EMPTY;
    else if (total > CMP_BITS'(max_cookie_bytes))
      verdict_next = V_OVERSIZE;
    else if (name_has_illegal)
      verdict_next = V_BAD_NAME;
    else if (value_has_illegal)
      verdict_next = V_BAD_VALUE;
    else if (CMP_BITS'(path_length) > CMP_BITS'(max_path_bytes))
      verdict_next = V_PATH_LONG;
    else if (path_has_tab)
      verdict_next = V_PATH_TAB;
    else if (CMP_BITS'(host_length) > CMP_BITS'(max_domain_bytes))
      verdict_next = V_HOST_LONG;
    else if (name_length == '0 && (has_sec || has_host))
      verdict_next = V_PREFIX;
    else if (none_insecure && none_requires_secure)
      verdict_next = V_NONE_SECURE;
    else begin
      warning_next = none_insecure;
      if (partition_needs_secure && s1_partitioned && !s1_secure)
        verdict_next = V_PART_SECURE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_is_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_is_end) begin
      out_verdict <= verdict_next;
      out_warning <= warning_next;
    end
  end

  assign result.valid               = out_valid;
  assign result.verdict             = out_verdict;
  assign result.none_secure_warning = out_warning;

  // an end item leaves the cookie state at its reset values
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && s1_is_end |=> name_length == '0 && value_length == '0
      && path_length == '0 && host_length == '0 && secure_prefix_alive
      && host_prefix_alive && !name_has_illegal)
    else $error("cookie state not cleared after end item");

  // byte items never shrink the name counter
  a_name_monotonic: assert property (@(posedge clk) disable iff (rst)
    advance && !s1_is_end |=> name_length >= $past(name_length))
    else $error("name length decreased on a byte item");

  // the warning comes only when the rule is not enforced and nothing earlier failed
  a_warning_ctx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_warning |-> !none_requires_secure
      && (out_verdict == V_OK || out_verdict == V_PART_SECURE))
    else $error("warning with an unexpected verdict");

  // a result is loaded only when the register was free or drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !(advance && s1_is_end))
    else $error("pending result overwritten");

  // the input side stalls only behind an end item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cookie.ready |-> s1_valid && s1_is_end && out_valid && !result.ready)
    else $error("input stalled without a pending end item");

endmodule

// File: test/cookie_attribute_validator_tb.sv
module cookie_attribute_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cav_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_PCT      = 26;
  localparam int HOLD_CYCLES   = 90;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;

  // tags the block has no use for
  localparam logic [2:0] TAG_SPARE_LO = 3'd5;
  localparam logic [2:0] TAG_SPARE_HI = 3'd7;

  localparam logic [1:0] SS_UNSET  = 2'd0;
  localparam logic [1:0] SS_LAX    = 2'd2;
  localparam logic [1:0] SS_STRICT = 2'd3;

  localparam logic [LIMIT_BITS-1:0] LIMIT_TOP = {LIMIT_BITS{1'b1}};

  localparam logic [8*SEC_PFX_LEN-1:0]  SECURE_PREFIX = "__secure-";
  localparam logic [8*HOST_PFX_LEN-1:0] HOST_PREFIX   = "__host-";

  localparam tag_t BYTE_TAGS [4] = '{TAG_NAME, TAG_VALUE, TAG_PATH, TAG_HOST};

  typedef enum int {PFX_NONE, PFX_SECURE, PFX_HOST} prefix_kind_t;

  typedef struct packed {
    logic [2:0] tag;
    logic [7:0] data;
    logic       secure;
    logic [1:0] same_site;
    logic       partitioned;
  } cookie_item_t;

  typedef struct packed {
    verdict_t verdict;
    logic     warn;
  } cookie_verdict_t;

  // character helpers
  function automatic bit ctl_char(input logic [7:0] c);
    return (c < 8'h20 && c != CH_TAB) || c == CH_SEMI || c == CH_DEL;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] secure_char(input int p);
    return SECURE_PREFIX[8*(SEC_PFX_LEN-1-p) +: 8];
  endfunction

  function automatic logic [7:0] host_char(input int p);
    return HOST_PREFIX[8*(HOST_PFX_LEN-1-p) +: 8];
  endfunction

  // mostly printable bytes, now and then anything
  function automatic logic [7:0] plain_byte();
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic cookie_item_t random_item();
    cookie_item_t it;
    it.tag         = TAG_NAME;
    it.data        = 8'($urandom);
    it.secure      = 1'($urandom);
    it.same_site   = 2'($urandom);
    it.partitioned = 1'($urandom);
    return it;
  endfunction

  function automatic cookie_item_t mk_item(input logic [2:0] tag, input logic [7:0] data,
                                           input logic secure, input logic [1:0] same_site,
                                           input logic partitioned);
    cookie_item_t it;
    it.tag         = tag;
    it.data        = data;
    it.secure      = secure;
    it.same_site   = same_site;
    it.partitioned = partitioned;
    return it;
  endfunction

  // tracks cookie state and settings, holds the verdicts still owed by the block
  class verdict_tracker;
    bit                     unicode_blocked;
    bit                     none_needs_secure;
    bit                     partition_needs_secure;
    logic [LIMIT_BITS-1:0]  cookie_limit;
    logic [LIMIT_BITS-1:0]  path_limit;
    logic [LIMIT_BITS-1:0]  host_limit;
    logic [LENGTH_BITS-1:0] name_len;
    logic [LENGTH_BITS-1:0] value_len;
    logic [LENGTH_BITS-1:0] path_len;
    logic [LENGTH_BITS-1:0] host_len;
    bit                     name_bad;
    bit                     value_bad;
    bit                     path_tab;
    bit                     secure_alive;
    bit                     host_alive;
    cookie_verdict_t        verdicts_due[$];
    int                     mismatches;

    function new();
      unicode_blocked        = 1'b0;
      none_needs_secure      = 1'b1;
      partition_needs_secure = 1'b1;
      cookie_limit           = MAX_COOKIE_RESET;
      path_limit             = MAX_PATH_RESET;
      host_limit             = MAX_DOMAIN_RESET;
      mismatches             = 0;
      clear_cookie();
    endfunction

    function void clear_cookie();
      name_len     = '0;
      value_len    = '0;
      path_len     = '0;
      host_len     = '0;
      name_bad     = 1'b0;
      value_bad    = 1'b0;
      path_tab     = 1'b0;
      secure_alive = 1'b1;
      host_alive   = 1'b1;
    endfunction

    function logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] v);
      return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    function void write_reg(input cfg_index_t idx, input logic [LIMIT_BITS-1:0] value);
      case (idx)
        CFG_BLOCK_UNICODE:   unicode_blocked        = value[0];
        CFG_NONE_REQ_SECURE: none_needs_secure      = value[0];
        CFG_PART_REQ_SECURE: partition_needs_secure = value[0];
        CFG_MAX_COOKIE:      cookie_limit           = value;
        CFG_MAX_PATH:        path_limit             = value;
        CFG_MAX_DOMAIN:      host_limit             = value;
        default: ;
      endcase
    endfunction

    // first failing check wins, warning survives a later partition reject
    function cookie_verdict_t judge_cookie(input cookie_item_t it);
      cookie_verdict_t r;
      bit has_sec;
      bit has_host;
      int total;
      r.verdict = V_OK;
      r.warn    = 1'b0;
      has_sec   = secure_alive && value_len >= SEC_PFX_LEN;
      has_host  = host_alive && value_len >= HOST_PFX_LEN;
      total     = int'(name_len) + int'(value_len);
      if (name_len == 0 && value_len == 0) r.verdict = V_EMPTY;
      else if (total > int'(cookie_limit)) r.verdict = V_OVERSIZE;
      else if (name_bad) r.verdict = V_BAD_NAME;
      else if (value_bad) r.verdict = V_BAD_VALUE;
      else if (path_len > path_limit) r.verdict = V_PATH_LONG;
      else if (path_tab) r.verdict = V_PATH_TAB;
      else if (host_len > host_limit) r.verdict = V_HOST_LONG;
      else if (name_len == 0 && (has_sec || has_host)) r.verdict = V_PREFIX;
      else begin
        if (!it.secure && it.same_site == SAME_SITE_NONE) begin
          if (none_needs_secure) r.verdict = V_NONE_SECURE;
          else r.warn = 1'b1;
        end
        if (r.verdict == V_OK && partition_needs_secure && it.partitioned && !it.secure)
          r.verdict = V_PART_SECURE;
      end
      return r;
    endfunction

    function void take_item(input cookie_item_t it);
      logic [7:0] c;
      logic [7:0] low;
      bit         wide;
      c    = it.data;
      low  = fold_case(c);
      wide = unicode_blocked && c[7];
      case (it.tag)
        TAG_NAME: begin
          if (wide || ctl_char(c) || c == CH_EQUAL) name_bad = 1'b1;
          name_len = bump(name_len);
        end
        TAG_VALUE: begin
          if (wide || ctl_char(c)) value_bad = 1'b1;
          if (value_len < SEC_PFX_LEN && low != secure_char(int'(value_len)))
            secure_alive = 1'b0;
          if (value_len < HOST_PFX_LEN && low != host_char(int'(value_len)))
            host_alive = 1'b0;
          value_len = bump(value_len);
        end
        TAG_PATH: begin
          if (c == CH_TAB) path_tab = 1'b1;
          path_len = bump(path_len);
        end
        TAG_HOST: host_len = bump(host_len);
        TAG_END: begin
          verdicts_due.push_back(judge_cookie(it));
          clear_cookie();
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(input logic [3:0] verdict, input logic warn);
      cookie_verdict_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: verdict %0d warning %0b", $realtime, verdict, warn);
      end else begin
        want = verdicts_due.pop_front();
        if (verdict !== want.verdict || warn !== want.warn) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected verdict %0d warning %0b, got verdict %0d warning %0b",
                     $realtime, want.verdict, want.warn, verdict, warn);
        end
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  cav_item_if   cookie_ch ();
  cav_result_if result_ch ();
  cav_cfg_if    cfg_ch ();

  cookie_attribute_validator dut (
    .clk    (clk),
    .rst    (rst),
    .cookie (cookie_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  verdict_tracker tracker;
  bit             idle_free;
  bit             hold_req;
  int             items_sent;

  // clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // offer one item, return after its transfer with valid still high
  task automatic send_item(input cookie_item_t it);
    while (!idle_free && $urandom_range(0, 99) < IDLE_PCT) begin
      cookie_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cookie_ch.valid            <= 1'b1;
    cookie_ch.field_tag        <= it.tag;
    cookie_ch.data_byte        <= it.data;
    cookie_ch.secure_attr      <= it.secure;
    cookie_ch.same_site        <= it.same_site;
    cookie_ch.partitioned_attr <= it.partitioned;
    do @(posedge clk); while (cookie_ch.ready !== 1'b1);
    tracker.take_item(it);
    if (it.tag <= TAG_END) items_sent++;
  endtask

  // stop offering and wait for every owed verdict plus the pipeline tail
  task automatic drain();
    cookie_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all six registers, flag registers get junk in their upper bits
  task automatic write_config(input bit uni, input bit nreq, input bit preq,
                              input logic [LIMIT_BITS-1:0] mc, input logic [LIMIT_BITS-1:0] mp,
                              input logic [LIMIT_BITS-1:0] md);
    logic [LIMIT_BITS-1:0] vals [6];
    cfg_index_t            idx;
    vals = '{{12'($urandom), uni}, {12'($urandom), nreq}, {12'($urandom), preq}, mc, mp, md};
    for (int i = 0; i < 6; i++) begin
      idx = cfg_index_t'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      tracker.write_reg(idx, vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one cookie: byte fields in order or interleaved, stray tags, then the end item
  task automatic send_cookie(input int name_n, input int value_n, input int path_n,
                             input int host_n, input prefix_kind_t pfx);
    int           left [4];
    int           pos;
    int           f;
    int           plen;
    int           bad_pos;
    bit           mixed;
    cookie_item_t it;
    left    = '{name_n, value_n, path_n, host_n};
    mixed   = ($urandom_range(0, 4) == 0);
    pos     = 0;
    plen    = (pfx == PFX_SECURE) ? SEC_PFX_LEN : (pfx == PFX_HOST) ? HOST_PFX_LEN : 0;
    bad_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plen) : -1;
    while (left[0] + left[1] + left[2] + left[3] > 0) begin
      if ($urandom_range(0, 39) == 0) begin
        it     = random_item();
        it.tag = 3'($urandom_range(TAG_SPARE_LO, TAG_SPARE_HI));
        send_item(it);
      end
      f = 0;
      if (mixed) begin
        do f = $urandom_range(0, 3); while (left[f] == 0);
      end else begin
        while (left[f] == 0) f++;
      end
      left[f]--;
      it     = random_item();
      it.tag = BYTE_TAGS[f];
      case (BYTE_TAGS[f])
        TAG_VALUE: begin
          if (pos < plen) begin
            if (pos != bad_pos) begin
              it.data = (pfx == PFX_SECURE) ? secure_char(pos) : host_char(pos);
              if ($urandom_range(0, 1) == 1) it.data = to_upper(it.data);
            end
          end else begin
            it.data = plain_byte();
          end
          pos++;
        end
        TAG_PATH: it.data = ($urandom_range(0, 14) == 0) ? CH_TAB : plain_byte();
        TAG_HOST: ;
        default:  it.data = plain_byte();
      endcase
      send_item(it);
    end
    it     = random_item();
    it.tag = TAG_END;
    send_item(it);
  endtask

  // random cookies until n more items went in
  task automatic run_random(input int n);
    int           start;
    int           nn;
    int           vn;
    int           pn;
    int           hn;
    prefix_kind_t pk;
    start = items_sent;
    while (items_sent - start < n) begin
      pk = prefix_kind_t'($urandom_range(0, 2));
      nn = (pk != PFX_NONE && $urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 6);
      case (pk)
        PFX_SECURE: vn = $urandom_range(SEC_PFX_LEN - 2, SEC_PFX_LEN + 4);
        PFX_HOST:   vn = $urandom_range(HOST_PFX_LEN - 2, HOST_PFX_LEN + 4);
        default:    vn = $urandom_range(0, 10);
      endcase
      if ($urandom_range(0, 11) == 0) begin
        nn = 0;
        vn = 0;
      end
      pn = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 6);
      hn = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 6);
      send_cookie(nn, vn, pn, hn, pk);
    end
  endtask

  // result side: check each transfer, then pick ready for the next edge
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        tracker.check_verdict(result_ch.verdict, result_ch.none_secure_warning);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_free) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (cookie_ch.valid === 1'b1 && cookie_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("cookie_attribute_validator regression: fail");
    $finish;
  end

  // stimulus
  initial begin
    tracker    = new();
    idle_free  = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    rst                        <= 1'b1;
    cookie_ch.valid            <= 1'b0;
    cookie_ch.field_tag        <= TAG_NAME;
    cookie_ch.data_byte        <= 8'h00;
    cookie_ch.secure_attr      <= 1'b0;
    cookie_ch.same_site        <= SS_UNSET;
    cookie_ch.partitioned_attr <= 1'b0;
    cfg_ch.valid               <= 1'b0;
    cfg_ch.index               <= CFG_BLOCK_UNICODE;
    cfg_ch.data                <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cookies on the reset settings
    // empty cookie
    send_item(mk_item(TAG_END, 8'h00, 1'b1, SS_LAX, 1'b0));
    // equals sign in the name
    send_item(mk_item(TAG_NAME, CH_EQUAL, 1'b0, SS_UNSET, 1'b0));
    send_item(mk_item(TAG_END, 8'hFF, 1'b1, SS_STRICT, 1'b1));
    // nul in the value
    send_item(mk_item(TAG_VALUE, 8'h00, 1'b1, SS_UNSET, 1'b0));
    send_item(mk_item(TAG_END, 8'h00, 1'b1, SS_LAX, 1'b0));
    // tab in the path
    send_item(mk_item(TAG_NAME, "a", 1'b0, SS_UNSET, 1'b0));
    send_item(mk_item(TAG_PATH, CH_TAB, 1'b0, SS_UNSET, 1'b0));
    send_item(mk_item(TAG_END, 8'h00, 1'b1, SS_LAX, 1'b0));
    // high bytes pass while unicode is allowed, stray tag ignored, none without secure
    send_item(mk_item(TAG_NAME, 8'hFF, 1'b1, SS_STRICT, 1'b1));
    send_item(mk_item(TAG_VALUE, 8'h80, 1'b0, SS_UNSET, 1'b0));
    send_item(mk_item(TAG_SPARE_HI, 8'hFF, 1'b1, SAME_SITE_NONE, 1'b1));
    send_item(mk_item(TAG_END, 8'h00, 1'b0, SAME_SITE_NONE, 1'b1));
    // upper case secure prefix on a nameless cookie
    for (int p = 0; p < SEC_PFX_LEN; p++)
      send_item(mk_item(TAG_VALUE, to_upper(secure_char(p)), 1'b0, SS_UNSET, 1'b0));
    send_item(mk_item(TAG_END, 8'h00, 1'b1, SS_STRICT, 1'b0));
    // partitioned without secure
    send_item(mk_item(TAG_NAME, "x", 1'b0, SS_UNSET, 1'b0));
    send_item(mk_item(TAG_END, 8'h00, 1'b0, SS_UNSET, 1'b1));
    drain();

    // small limits, warning instead of reject; long output stall while ends keep coming
    write_config(1'b1, 1'b0, 1'b0, 13'd20, 13'd8, 13'd8);
    hold_req  = 1'b1;
    idle_free = 1'b1;
    repeat (14) begin
      send_item(mk_item(TAG_NAME, "k", 1'b0, SS_UNSET, 1'b0));
      send_item(mk_item(TAG_END, 8'h00, 1'b1, SS_LAX, 1'b0));
    end
    idle_free = 1'b0;
    run_random(200);
    drain();

    // all limits at zero
    write_config(1'b0, 1'b0, 1'b1, '0, '0, '0);
    run_random(100);
    drain();

    // all limits at the top
    write_config(1'b1, 1'b1, 1'b0, LIMIT_TOP, LIMIT_TOP, LIMIT_TOP);
    run_random(120);
    drain();

    // random settings, one phase with no idling on either side
    for (int ph = 0; ph < 6; ph++) begin
      idle_free = (ph == 2);
      write_config(1'($urandom), 1'($urandom), 1'($urandom),
                   ($urandom_range(0, 5) == 0) ? MAX_COOKIE_RESET : 13'($urandom_range(2, 24)),
                   ($urandom_range(0, 5) == 0) ? MAX_PATH_RESET : 13'($urandom_range(0, 10)),
                   ($urandom_range(0, 5) == 0) ? MAX_DOMAIN_RESET : 13'($urandom_range(0, 10)));
      run_random(210);
      drain();
    end
    idle_free = 1'b0;

    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("cookie_attribute_validator regression: pass");
    else
      $display("cookie_attribute_validator regression: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/cav_pkg.sv
rtl/cav_if.sv
rtl/cookie_attribute_validator.sv
test/cookie_attribute_validator_tb.sv
